>>> rtl/core/pcgksw_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the PCG keyed substitution word cipher.
// No dependencies; imported by every module of the block.
package pcgksw_pkg;

  // Item operations
  localparam logic [1:0] OP_LOAD_FWD = 2'd0;
  localparam logic [1:0] OP_LOAD_REV = 2'd1;
  localparam logic [1:0] OP_START    = 2'd2;
  localparam logic [1:0] OP_DATA     = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_SEED_LO = 3'd0;
  localparam logic [2:0] CFG_SEED_HI = 3'd1;
  localparam logic [2:0] CFG_ANCHOR  = 3'd2;
  localparam logic [2:0] CFG_MASK    = 3'd3;
  localparam logic [2:0] CFG_DIR     = 3'd4;

  // PCG64 LCG multiplier and increment (stream 5)
  localparam logic [127:0] PCG_MUL = {64'h2360ED051FC65DA4, 64'h4385DF649FCCF645};
  localparam logic [127:0] PCG_INC = 128'd11;

  // Number of 32x32 partial products that land in the low 128 bits
  localparam int unsigned NUM_PP = 10;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  idx;
    logic [7:0]  val;
    logic [63:0] word;
  } item_t;

  typedef struct packed {
    logic busy;  // back end working on an item
    logic fin;   // result being written to the output register
  } bk_status_t;

  function automatic logic [63:0] rotr64(input logic [63:0] x, input logic [5:0] r);
    logic [6:0] l;
    l = 7'd64 - {1'b0, r};
    return (x >> r) | (x << l);
  endfunction

  function automatic logic [31:0] limb32(input logic [127:0] x, input logic [1:0] sel);
    return x[{sel, 5'b0} +: 32];
  endfunction

  // Limb pairs (i, j) with i + j <= 3, one per multiplier pass
  function automatic logic [1:0] pp_a(input logic [3:0] k);
    logic [1:0] r;
    case (k)
      4'd0, 4'd1, 4'd3, 4'd6: r = 2'd0;
      4'd2, 4'd4, 4'd7:       r = 2'd1;
      4'd5, 4'd8:             r = 2'd2;
      4'd9:                   r = 2'd3;
      default:                r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pp_b(input logic [3:0] k);
    logic [1:0] r;
    case (k)
      4'd0, 4'd2, 4'd5, 4'd9: r = 2'd0;
      4'd1, 4'd4, 4'd8:       r = 2'd1;
      4'd3, 4'd7:             r = 2'd2;
      4'd6:                   r = 2'd3;
      default:                r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/pcg_keyed_substitution_word_cipher_top.sv
`timescale 1ns / 1ps
// Top level of the PCG keyed substitution word cipher: config registers,
// front queue and back end. Depends on pcgksw_pkg, pcgksw_front, pcgksw_back.

// Items enter a two-entry queue and are carried out one at a time by the back
// end. A load is written as it is popped; start and data items wait on the PCG
// state advance (ten 32x32 products through one multiplier), data words also
// on eight byte reads from a substitution table. The user must read back only
// loaded table entries and write configuration through cfg_we/cfg_index/
// cfg_wdata only while idle; the block enforces neither.
module pcg_keyed_substitution_word_cipher_top import pcgksw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_table_index,
  input  logic [7:0]  in_table_value,
  input  logic [63:0] in_data_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_word,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  logic [63:0] seed_lo_r, seed_hi_r, anchor_r, mask_r;
  logic        dir_r;
  item_t       in_item, q_item;
  logic        q_valid, q_pop;
  logic [1:0]  q_cnt;
  bk_status_t  bk_st;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_lo_r <= '0;
      seed_hi_r <= '0;
      anchor_r  <= '0;
      mask_r    <= '0;
      dir_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEED_LO: seed_lo_r <= cfg_wdata;
        CFG_SEED_HI: seed_hi_r <= cfg_wdata;
        CFG_ANCHOR:  anchor_r  <= cfg_wdata;
        CFG_MASK:    mask_r    <= cfg_wdata;
        CFG_DIR:     dir_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_item = '{op: in_operation, idx: in_table_index,
                     val: in_table_value, word: in_data_word};

  pcgksw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .q_cnt    (q_cnt)
  );

  pcgksw_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .seed_lo      (seed_lo_r),
    .seed_hi      (seed_hi_r),
    .anchor_start (anchor_r),
    .mask         (mask_r),
    .dir          (dir_r),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_word     (out_result_word),
    .status       (bk_st)
  );

  // checks
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(bk_st.fin))
    else $error("result appeared without a finished data item");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !bk_st.busy)
    else $error("queue popped while back end busy");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt != 2'd3)
    else $error("queue overfilled");

endmodule

>>> rtl/core/pcgksw_front.sv
`timescale 1ns / 1ps
// Front end: accepts input items into a two-entry queue for the back end.
// Depends on pcgksw_pkg.
module pcgksw_front import pcgksw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  item_t       in_item,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop,
  output logic [1:0]  q_cnt
);

  item_t      ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = ent_r[rp_r];
  assign q_cnt    = cnt_r;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= in_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

>>> rtl/core/pcgksw_gen.sv
`timescale 1ns / 1ps
// PCG64 state advance: state * MUL + INC mod 2^128, one 32x32 product a cycle.
// Depends on pcgksw_pkg.
module pcgksw_gen import pcgksw_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] state_in,
  output logic         done,
  output logic [127:0] state_out
);

  logic         busy_r;
  logic [3:0]   k_r;
  logic [127:0] a_r;
  logic [127:0] acc_r;
  logic [63:0]  p_r;
  logic [1:0]   sh_r;
  logic         pv_r;
  logic [1:0]   ia, ib;

  assign ia        = pp_a(k_r);
  assign ib        = pp_b(k_r);
  assign done      = busy_r && (k_r == 4'(NUM_PP)) && !pv_r;
  assign state_out = acc_r + PCG_INC;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      k_r    <= 4'd0;
      pv_r   <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      k_r    <= 4'd0;
      pv_r   <= 1'b0;
    end else if (busy_r) begin
      pv_r <= (k_r != 4'(NUM_PP));
      if (k_r != 4'(NUM_PP)) k_r <= k_r + 4'd1;
      if (done) busy_r <= 1'b0;
    end
  end

  // partial product register, then accumulate
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= state_in;
      acc_r <= '0;
    end else begin
      p_r  <= limb32(a_r, ia) * limb32(PCG_MUL, ib);
      sh_r <= ia + ib;
      if (pv_r) acc_r <= acc_r + ({64'b0, p_r} << {sh_r, 5'b0});
    end
  end

endmodule

>>> rtl/core/pcgksw_back.sv
`timescale 1ns / 1ps
// Back end: tables, key stream, anchor/chain state and the result register.
// Depends on pcgksw_pkg and pcgksw_gen.
module pcgksw_back import pcgksw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  input  logic [63:0] seed_lo,
  input  logic [63:0] seed_hi,
  input  logic [63:0] anchor_start,
  input  logic [63:0] mask,
  input  logic        dir,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_word,
  output bk_status_t  status
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GEN  = 3'd1;
  localparam logic [2:0] S_KEY  = 3'd2;
  localparam logic [2:0] S_SUB  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]   st_r, st_nxt;
  logic [127:0] pcg_r;
  logic [63:0]  anchor_r, chain_r, word_r, mask_r, key_r, opnd_r, sub_r, out_word_r;
  logic         dir_r, is_start_r, out_valid_r;
  logic [3:0]   sc_r;
  logic [7:0]   fwd_mem [256];
  logic [7:0]   rev_mem [256];
  logic [7:0]   fwd_rd_r, rev_rd_r, rd_addr;
  logic         gen_start, gen_done, fin;
  logic [127:0] gen_in, gen_out;
  logic [63:0]  key, anchor_new, sub_nxt;
  logic [2:0]   bsel;

  pcgksw_gen u_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (gen_start),
    .state_in  (gen_in),
    .done      (gen_done),
    .state_out (gen_out)
  );

  assign q_pop     = (st_r == S_IDLE) && q_valid;
  assign gen_start = q_pop && (q_item.op == OP_START || q_item.op == OP_DATA);
  // seeding folds the first step from zero (which yields INC) into the seed add
  assign gen_in    = (q_item.op == OP_START) ? ({seed_hi, seed_lo} + PCG_INC) : pcg_r;

  // XSL-RR output and anchor rotation
  assign key        = rotr64(pcg_r[127:64] ^ pcg_r[63:0], pcg_r[127:122]);
  assign anchor_new = rotr64(anchor_r, key[5:0]);

  assign fin       = (st_r == S_FIN) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign status    = '{busy: (st_r != S_IDLE), fin: fin};

  // state sequencing
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (gen_start) st_nxt = S_GEN;
      S_GEN:  if (gen_done) st_nxt = is_start_r ? S_IDLE : S_KEY;
      S_KEY:  st_nxt = S_SUB;
      S_SUB:  if (sc_r == 4'd8) st_nxt = S_FIN;
      S_FIN:  if (fin) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // table writes and registered byte reads
  assign rd_addr = opnd_r[{sc_r[2:0], 3'b0} +: 8];

  always_ff @(posedge clk) begin
    if (q_pop && q_item.op == OP_LOAD_FWD) fwd_mem[q_item.idx] <= q_item.val;
    fwd_rd_r <= fwd_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.op == OP_LOAD_REV) rev_mem[q_item.idx] <= q_item.val;
    rev_rd_r <= rev_mem[rd_addr];
  end

  // substituted word assembly, one byte a cycle
  assign bsel = sc_r[2:0] - 3'd1;
  always_comb begin
    sub_nxt = sub_r;
    sub_nxt[{bsel, 3'b0} +: 8] = dir_r ? rev_rd_r : fwd_rd_r;
  end

  // cipher state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcg_r       <= '0;
      anchor_r    <= '0;
      chain_r     <= '0;
      out_valid_r <= 1'b0;
      is_start_r  <= 1'b0;
      sc_r        <= 4'd0;
    end else begin
      if (gen_start) begin
        is_start_r <= (q_item.op == OP_START);
        word_r     <= q_item.word;
        mask_r     <= mask;
        dir_r      <= dir;
      end
      if (st_r == S_GEN && gen_done) begin
        pcg_r <= gen_out;
        if (is_start_r) begin
          anchor_r <= anchor_start;
          chain_r  <= anchor_start;
        end
      end
      if (st_r == S_KEY) begin
        anchor_r <= anchor_new;
        key_r    <= key;
        opnd_r   <= dir_r ? (word_r ^ key ^ anchor_new) : (chain_r ^ word_r ^ mask_r);
        sc_r     <= 4'd0;
      end
      if (st_r == S_SUB) begin
        sc_r <= sc_r + 4'd1;
        if (sc_r != 4'd0) sub_r <= sub_nxt;
      end
      // result register
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (fin) begin
        out_valid_r <= 1'b1;
        if (dir_r) begin
          out_word_r <= chain_r ^ sub_r ^ mask_r;
          chain_r    <= opnd_r;
        end else begin
          out_word_r <= sub_r ^ key_r ^ anchor_r;
          chain_r    <= sub_r;
        end
      end
    end
  end

endmodule

>>> bench/pcg_keyed_substitution_word_cipher_top_test.sv
`timescale 1ns / 1ps
// Testbench for the PCG keyed substitution word cipher: table loads, message
// starts and data words under random stalls, checked against an own predictor.
// Depends on pcgksw_pkg and pcg_keyed_substitution_word_cipher_top.

// Tracks the cipher state and holds the words the block should return
class cipher_scoreboard;
  localparam bit [127:0] LCG_MULT = {64'd2549297995355413924, 64'd4865540595714422341};
  localparam bit [127:0] LCG_INC  = 128'd11;

  bit [63:0]  seed_lo, seed_hi, anchor_init, mask;
  bit         decrypt;
  bit [127:0] lcg;
  bit [63:0]  anchor, chain;
  bit [7:0]   fwd_sbox[256];
  bit [7:0]   rev_sbox[256];
  bit [63:0]  pending_words[$];
  int         errors;

  function void write_reg(bit [2:0] index, bit [63:0] value);
    case (index)
      pcgksw_pkg::CFG_SEED_LO: seed_lo = value;
      pcgksw_pkg::CFG_SEED_HI: seed_hi = value;
      pcgksw_pkg::CFG_ANCHOR:  anchor_init = value;
      pcgksw_pkg::CFG_MASK:    mask = value;
      pcgksw_pkg::CFG_DIR:     decrypt = value[0];
      default: ;
    endcase
  endfunction

  function bit [63:0] ror(bit [63:0] x, bit [5:0] r);
    bit [127:0] d;
    d = {x, x} >> r;
    return d[63:0];
  endfunction

  function bit [63:0] draw_key();
    lcg = lcg * LCG_MULT + LCG_INC;
    return ror(lcg[127:64] ^ lcg[63:0], lcg[127:122]);
  endfunction

  function bit [63:0] sub_bytes(bit [63:0] w, bit use_rev);
    bit [63:0] r;
    for (int k = 0; k < 8; k++)
      r[8*k +: 8] = use_rev ? rev_sbox[w[8*k +: 8]] : fwd_sbox[w[8*k +: 8]];
    return r;
  endfunction

  // Apply one accepted request; data words queue an expected result
  function void note_request(bit [1:0] op, bit [7:0] idx, bit [7:0] val, bit [63:0] word);
    bit [63:0] key, mixed;
    case (op)
      pcgksw_pkg::OP_LOAD_FWD: fwd_sbox[idx] = val;
      pcgksw_pkg::OP_LOAD_REV: rev_sbox[idx] = val;
      pcgksw_pkg::OP_START: begin
        lcg = LCG_INC + {seed_hi, seed_lo};
        lcg = lcg * LCG_MULT + LCG_INC;
        anchor = anchor_init;
        chain = anchor_init;
      end
      default: begin
        key = draw_key();
        anchor = ror(anchor, key[5:0]);
        if (!decrypt) begin
          mixed = sub_bytes(chain ^ word ^ mask, 1'b0);
          pending_words.push_back(mixed ^ key ^ anchor);
        end else begin
          mixed = word ^ key ^ anchor;
          pending_words.push_back(chain ^ sub_bytes(mixed, 1'b1) ^ mask);
        end
        chain = mixed;
      end
    endcase
  endfunction

  task report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  task check_result(bit [63:0] got);
    bit [63:0] want;
    if (pending_words.size() == 0) begin
      report_mismatch($sformatf("unexpected result %h", got));
      return;
    end
    want = pending_words.pop_front();
    if (got !== want)
      report_mismatch($sformatf("result_word %h, expected %h", got, want));
  endtask
endclass

module pcg_keyed_substitution_word_cipher_top_test;
  import pcgksw_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = OP_LOAD_FWD;
  logic [7:0]  in_table_index = '0;
  logic [7:0]  in_table_value = '0;
  logic [63:0] in_data_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_result_word;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_SEED_LO;
  logic [63:0] cfg_wdata = '0;

  cipher_scoreboard sb = new();
  bit quiet = 1'b0;
  int results_seen = 0;

  always #4 clk = ~clk;

  pcg_keyed_substitution_word_cipher_top DUT (.*);

  // Overall watchdog
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  function bit [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Offer one request, with an occasional idle burst ahead of it
  task send(bit [1:0] op, bit [7:0] idx, bit [7:0] val, bit [63:0] word);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_table_index <= idx;
    in_table_value <= val;
    in_data_word <= word;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    sb.note_request(op, idx, val, word);
    @(negedge clk);
  endtask

  // One register write; the enable drops again before the next call
  task write_reg(bit [2:0] index, bit [63:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    sb.write_reg(index, value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Drain outstanding words, then allow a start or load to finish
  task wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_words.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function bit [63:0] pick_extreme();
    case ($urandom_range(0, 2))
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  // Result side: random stall bursts plus one long hold-off
  initial begin
    int stall_left;
    bit held;
    stall_left = 0;
    held = 1'b0;
    @(negedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_result(out_result_word);
        results_seen++;
      end
      @(negedge clk);
      if (!held && results_seen == 30) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int r;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Fill both tables: an odd-multiplier permutation and its inverse
    for (int i = 0; i < 256; i++) begin
      send(OP_LOAD_FWD, i[7:0], 8'(i * 167 + 13), 64'd0);
      send(OP_LOAD_REV, 8'(i * 167 + 13), i[7:0], 64'd0);
    end

    // Directed: data before any start, extremes of fields and loads
    send(OP_DATA, 8'd0, 8'd0, 64'd0);
    send(OP_DATA, 8'hff, 8'hff, '1);
    send(OP_START, 8'd0, 8'd0, 64'd0);
    send(OP_DATA, 8'd0, 8'd0, 64'd0);
    send(OP_DATA, 8'd0, 8'd0, '1);
    send(OP_LOAD_FWD, 8'd0, 8'hff, 64'd0);
    send(OP_LOAD_REV, 8'hff, 8'd0, '1);
    send(OP_DATA, 8'd0, 8'd0, 64'h0123456789abcdef);
    send(OP_LOAD_FWD, 8'hff, 8'd0, 64'd0);
    send(OP_DATA, 8'd0, 8'd0, 64'hffffffff00000000);
    wait_idle();

    // Phases under changing settings; the first two hit the extremes
    for (int p = 0; p < 7; p++) begin
      if (p == 6) quiet = 1'b1;
      write_reg(CFG_SEED_LO, p == 0 ? 64'd0 : p == 1 ? '1 : pick_extreme());
      write_reg(CFG_SEED_HI, p == 0 ? 64'd0 : p == 1 ? '1 : pick_extreme());
      write_reg(CFG_ANCHOR, p == 0 ? 64'd0 : p == 1 ? '1 : pick_extreme());
      write_reg(CFG_MASK, p == 0 ? 64'd0 : p == 1 ? '1 : pick_extreme());
      write_reg(CFG_DIR, 64'({rand64() >> 1, p[0]}));
      send(OP_START, 8'($urandom()), 8'($urandom()), rand64());
      for (int n = 0; n < 175; n++) begin
        r = $urandom_range(0, 99);
        if (r < 4)
          send(OP_START, 8'($urandom()), 8'($urandom()), rand64());
        else if (r < 10)
          send(r[0] ? OP_LOAD_FWD : OP_LOAD_REV, 8'($urandom()), 8'($urandom()),
               rand64());
        else
          send(OP_DATA, 8'($urandom()), 8'($urandom()),
               r < 14 ? pick_extreme() : rand64());
      end
      wait_idle();
    end

    if (sb.pending_words.size() == 0 && sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
